### hw/rtl/pdp_pkg.sv
// Shared types and constants for the PDP-11 ALU with condition codes.
// No dependencies; every other file of the block imports it.
package pdp_pkg;

    localparam logic [4:0] K_MOV    = 5'd0;
    localparam logic [4:0] K_CMP    = 5'd1;
    localparam logic [4:0] K_BIT    = 5'd2;
    localparam logic [4:0] K_BIC    = 5'd3;
    localparam logic [4:0] K_BIS    = 5'd4;
    localparam logic [4:0] K_ADD    = 5'd5;
    localparam logic [4:0] K_SUB    = 5'd6;
    localparam logic [4:0] K_CLR    = 5'd7;
    localparam logic [4:0] K_COM    = 5'd8;
    localparam logic [4:0] K_INC    = 5'd9;
    localparam logic [4:0] K_DEC    = 5'd10;
    localparam logic [4:0] K_NEG    = 5'd11;
    localparam logic [4:0] K_ADC    = 5'd12;
    localparam logic [4:0] K_SBC    = 5'd13;
    localparam logic [4:0] K_TST    = 5'd14;
    localparam logic [4:0] K_ROR    = 5'd15;
    localparam logic [4:0] K_ROL    = 5'd16;
    localparam logic [4:0] K_ASR    = 5'd17;
    localparam logic [4:0] K_ASL    = 5'd18;
    localparam logic [4:0] K_SWAB   = 5'd19;
    localparam logic [4:0] K_SXT    = 5'd20;
    localparam logic [4:0] K_XOR    = 5'd21;
    localparam logic [4:0] K_MUL    = 5'd22;
    localparam logic [4:0] K_DIV    = 5'd23;
    localparam logic [4:0] K_ASH    = 5'd24;
    localparam logic [4:0] K_ASHC   = 5'd25;
    localparam logic [4:0] K_CCC    = 5'd26;
    localparam logic [4:0] K_BRANCH = 5'd27;

    localparam logic [3:0] BR_NEVER  = 4'd0;
    localparam logic [3:0] BR_ALWAYS = 4'd1;
    localparam logic [3:0] BR_NE     = 4'd2;
    localparam logic [3:0] BR_EQ     = 4'd3;
    localparam logic [3:0] BR_GE     = 4'd4;
    localparam logic [3:0] BR_LT     = 4'd5;
    localparam logic [3:0] BR_GT     = 4'd6;
    localparam logic [3:0] BR_LE     = 4'd7;
    localparam logic [3:0] BR_PL     = 4'd8;
    localparam logic [3:0] BR_MI     = 4'd9;
    localparam logic [3:0] BR_HI     = 4'd10;
    localparam logic [3:0] BR_LOS    = 4'd11;
    localparam logic [3:0] BR_VC     = 4'd12;
    localparam logic [3:0] BR_VS     = 4'd13;
    localparam logic [3:0] BR_CC     = 4'd14;
    localparam logic [3:0] BR_CS     = 4'd15;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CL_ALU,
        CL_MUL,
        CL_DIV
    } op_class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } back_state_t;

    typedef struct packed {
        op_class_t   cls;
        logic        byteop;
        logic [4:0]  kind;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] lo;
        logic        odd;
        logic [4:0]  cm;
    } op_entry_t;

    typedef struct packed {
        logic done;
        logic div_zero;
        logic overflow;
    } div_status_t;

endpackage

### hw/rtl/pdp_front.sv
// Front end: takes input transactions and classifies them for the back end.
// Depends on pdp_pkg.
module pdp_front import pdp_pkg::*; (
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_kind,
    input  logic        s_byte_mode,
    input  logic [15:0] s_source_value,
    input  logic [15:0] s_dest_value,
    input  logic [15:0] s_pair_low_value,
    input  logic        s_pair_is_odd,
    input  logic [4:0]  s_cond_or_mask,
    output logic        push_valid,
    input  logic        push_ready,
    output op_entry_t   push_entry
);

    always_comb begin
        push_valid        = s_valid;
        s_ready           = push_ready;
        push_entry.kind   = s_kind;
        push_entry.src    = s_source_value;
        push_entry.dst    = s_dest_value;
        push_entry.lo     = s_pair_low_value;
        push_entry.odd    = s_pair_is_odd;
        push_entry.cm     = s_cond_or_mask;
        // byte variant only for the classic ops, never add or sub
        push_entry.byteop = s_byte_mode && (s_kind <= K_ASL) &&
                            (s_kind != K_ADD) && (s_kind != K_SUB);
        if (s_kind == K_MUL) begin
            push_entry.cls = CL_MUL;
        end else if (s_kind == K_DIV) begin
            push_entry.cls = CL_DIV;
        end else begin
            push_entry.cls = CL_ALU;
        end
    end

endmodule

### hw/rtl/pdp_queue.sv
// Two-entry queue of classified operations between front and back end.
// Depends on pdp_pkg.
module pdp_queue import pdp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  op_entry_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output op_entry_t out_data
);

    op_entry_t  entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb begin
        in_ready    = (count_reg != 2'(QUEUE_DEPTH));
        out_valid   = (count_reg != 2'd0);
        out_data    = entry_reg[rd_ptr_reg];
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### hw/rtl/pdp_div.sv
// Radix-2 restoring divider, 32-bit signed dividend by 16-bit signed divisor.
// Depends on pdp_pkg. One quotient bit per cycle.
module pdp_div import pdp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output div_status_t status,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);

    logic        busy_reg, done_reg, dz_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [15:0] rem_reg, dvs_reg;
    logic        dvd_neg_reg, dvs_neg_reg;
    logic [16:0] rem_sh;
    logic [17:0] diff;
    logic        ge, q_neg;

    always_comb begin
        rem_sh           = {rem_reg, quo_reg[31]};
        diff             = {1'b0, rem_sh} - {2'b00, dvs_reg};
        ge               = !diff[17];
        q_neg            = dvd_neg_reg ^ dvs_neg_reg;
        status.done      = done_reg;
        status.div_zero  = dz_reg;
        status.overflow  = q_neg ? (quo_reg > 32'd32768) : (quo_reg > 32'd32767);
        quotient         = q_neg ? (16'd0 - quo_reg[15:0]) : quo_reg[15:0];
        remainder        = dvd_neg_reg ? (16'd0 - rem_reg) : rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else if (start) begin
            busy_reg <= (divisor != 16'd0);
            done_reg <= (divisor == 16'd0);
            cnt_reg  <= 5'd0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dz_reg      <= (divisor == 16'd0);
            dvd_neg_reg <= dividend[31];
            dvs_neg_reg <= divisor[15];
            quo_reg     <= dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_reg     <= divisor[15] ? (16'd0 - divisor) : divisor;
            rem_reg     <= 16'd0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[15:0] : rem_sh[15:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

endmodule

### hw/rtl/pdp_back.sv
// Back end: executes queued operations, keeps N Z V C, drives the result port.
// Depends on pdp_pkg and pdp_div.
module pdp_back import pdp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  op_entry_t   q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_word,
    output logic [15:0] m_result_low_word,
    output logic        m_write_result,
    output logic        m_write_pair_low,
    output logic        m_branch_taken,
    output logic [3:0]  m_flags_out
);

    function automatic logic [3:0] mkf(input logic [15:0] r, input logic [15:0] m,
                                       input logic [15:0] s, input logic v,
                                       input logic c);
        return {|(r & s), (r & m) == 16'd0, v, c};
    endfunction

    // returns {N,Z,V,C, result[31:0]}
    function automatic logic [35:0] shift_op(input logic [31:0] val, input logic is16,
                                             input logic [5:0] cnt, input logic cold);
        logic [63:0]        m, u, top, fm, res;
        logic signed [63:0] s;
        logic [5:0]         n;
        logic               c, ov;
        logic [31:0]        sb;
        m   = is16 ? 64'h0000_0000_0000_FFFF : 64'h0000_0000_FFFF_FFFF;
        sb  = is16 ? 32'h0000_8000 : 32'h8000_0000;
        ov  = 1'b0;
        c   = cold;
        res = {32'd0, val} & m;
        if (cnt == 6'd0) begin
            ov = 1'b0;
        end else if (!cnt[5]) begin
            n   = cnt;
            u   = ({32'd0, val} & m) << n;
            top = is16 ? (u >> 15) : (u >> 31);
            fm  = (64'd1 << (n + 6'd1)) - 64'd1;
            res = u & m;
            c   = is16 ? u[16] : u[32];
            ov  = (top != 64'd0) && (top != fm);
        end else begin
            n   = 6'd0 - cnt;
            s   = is16 ? signed'({{48{val[15]}}, val[15:0]}) : signed'({{32{val[31]}}, val});
            c   = s[n - 6'd1];
            res = 64'(s >>> n) & m;
        end
        return {|(res[31:0] & sb), res == 64'd0, ov, c, res[31:0]};
    endfunction

    function automatic logic cond_true(input logic [3:0] sel, input logic [3:0] f);
        logic n, z, v, c;
        n = f[3];
        z = f[2];
        v = f[1];
        c = f[0];
        unique case (sel)
            BR_NEVER:  return 1'b0;
            BR_ALWAYS: return 1'b1;
            BR_NE:     return !z;
            BR_EQ:     return z;
            BR_GE:     return !(n ^ v);
            BR_LT:     return n ^ v;
            BR_GT:     return !(z || (n ^ v));
            BR_LE:     return z || (n ^ v);
            BR_PL:     return !n;
            BR_MI:     return n;
            BR_HI:     return !(c || z);
            BR_LOS:    return c || z;
            BR_VC:     return !v;
            BR_VS:     return v;
            BR_CC:     return !c;
            BR_CS:     return c;
            default:   return 1'b0;
        endcase
    endfunction

    back_state_t state_reg, state_next;
    logic [3:0]  flags_reg, flags_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] word_reg, word_next, low_reg, low_next;
    logic        wr_reg, wr_next, wl_reg, wl_next, br_reg, br_next;
    logic [31:0] prod_reg, prod_next;
    logic        odd_reg, odd_next;
    logic        out_free, load;
    logic        div_start;
    div_status_t div_st;
    logic [15:0] div_q, div_r;

    // combinational datapath results
    logic [15:0] mm, ss, a, b, r, rlo, rfin;
    logic [16:0] sum;
    logic [3:0]  nf;
    logic [35:0] sh;
    logic        t, wr, wl, br, c_in;

    pdp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  ({q_data.dst, q_data.lo}),
        .divisor   (q_data.src),
        .status    (div_st),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        c_in = flags_reg[0];
        mm   = q_data.byteop ? 16'h00FF : 16'hFFFF;
        ss   = q_data.byteop ? 16'h0080 : 16'h8000;
        a    = q_data.src & mm;
        b    = q_data.dst & mm;
        r    = 16'd0;
        rlo  = 16'd0;
        nf   = flags_reg;
        wr   = 1'b0;
        wl   = 1'b0;
        br   = 1'b0;
        sum  = 17'd0;
        t    = 1'b0;
        sh   = 36'd0;
        unique case (q_data.kind)
            K_MOV: begin
                r = a; nf = mkf(r, mm, ss, 1'b0, c_in); wr = 1'b1;
            end
            K_CMP: begin
                r  = (a - b) & mm;
                nf = mkf(r, mm, ss, |((a ^ b) & (a ^ r) & ss), a < b);
            end
            K_BIT: begin
                r = a & b; nf = mkf(r, mm, ss, 1'b0, c_in);
            end
            K_BIC: begin
                r = ~a & b & mm; nf = mkf(r, mm, ss, 1'b0, c_in); wr = 1'b1;
            end
            K_BIS: begin
                r = a | b; nf = mkf(r, mm, ss, 1'b0, c_in); wr = 1'b1;
            end
            K_ADD: begin
                sum = {1'b0, a} + {1'b0, b};
                r   = sum[15:0] & mm;
                nf  = mkf(r, mm, ss, |(~(a ^ b) & (a ^ r) & ss), sum > {1'b0, mm});
                wr  = 1'b1;
            end
            K_SUB: begin
                r  = (b - a) & mm;
                nf = mkf(r, mm, ss, |((a ^ b) & (b ^ r) & ss), b < a);
                wr = 1'b1;
            end
            K_CLR: begin
                r = 16'd0; nf = 4'b0100; wr = 1'b1;
            end
            K_COM: begin
                r = ~b & mm; nf = mkf(r, mm, ss, 1'b0, 1'b1); wr = 1'b1;
            end
            K_INC: begin
                r = (b + 16'd1) & mm; nf = mkf(r, mm, ss, r == ss, c_in); wr = 1'b1;
            end
            K_DEC: begin
                r = (b - 16'd1) & mm; nf = mkf(r, mm, ss, b == ss, c_in); wr = 1'b1;
            end
            K_NEG: begin
                r  = (16'd0 - b) & mm;
                nf = mkf(r, mm, ss, r == ss, r != 16'd0);
                wr = 1'b1;
            end
            K_ADC: begin
                r  = (b + {15'd0, c_in}) & mm;
                nf = mkf(r, mm, ss, c_in && (b == ss - 16'd1), c_in && (b == mm));
                wr = 1'b1;
            end
            K_SBC: begin
                r  = (b - {15'd0, c_in}) & mm;
                nf = mkf(r, mm, ss, c_in && (b == ss), c_in && (b == 16'd0));
                wr = 1'b1;
            end
            K_TST: begin
                r = b; nf = mkf(r, mm, ss, 1'b0, 1'b0);
            end
            K_ROR, K_ROL, K_ASR, K_ASL: begin
                priority case (q_data.kind)
                    K_ROR: begin
                        r = (b >> 1) | (c_in ? ss : 16'd0); t = b[0];
                    end
                    K_ROL: begin
                        r = ((b << 1) | {15'd0, c_in}) & mm; t = |(b & ss);
                    end
                    K_ASR: begin
                        r = (b >> 1) | (b & ss); t = b[0];
                    end
                    default: begin
                        r = (b << 1) & mm; t = |(b & ss);
                    end
                endcase
                nf = mkf(r, mm, ss, (|(r & ss)) ^ t, t);
                wr = 1'b1;
            end
            K_SWAB: begin
                r  = {q_data.dst[7:0], q_data.dst[15:8]};
                nf = mkf(r, 16'h00FF, 16'h0080, 1'b0, 1'b0);
                wr = 1'b1;
            end
            K_SXT: begin
                r  = flags_reg[3] ? 16'hFFFF : 16'h0000;
                nf = {flags_reg[3], !flags_reg[3], 1'b0, c_in};
                wr = 1'b1;
            end
            K_XOR: begin
                r  = q_data.src ^ q_data.dst;
                nf = mkf(r, 16'hFFFF, 16'h8000, 1'b0, c_in);
                wr = 1'b1;
            end
            K_ASH: begin
                sh = shift_op({16'd0, q_data.dst}, 1'b1, q_data.src[5:0], c_in);
                r  = sh[15:0]; nf = sh[35:32]; wr = 1'b1;
            end
            K_ASHC: begin
                sh  = shift_op({q_data.dst, q_data.lo}, 1'b0, q_data.src[5:0], c_in);
                r   = sh[31:16]; rlo = sh[15:0]; nf = sh[35:32];
                wr  = 1'b1; wl = 1'b1;
            end
            K_CCC: begin
                nf = q_data.cm[4] ? (flags_reg | q_data.cm[3:0])
                                  : (flags_reg & ~q_data.cm[3:0]);
            end
            K_BRANCH: begin
                br = cond_true(q_data.cm[3:0], flags_reg);
            end
            default: begin
                nf = flags_reg;
            end
        endcase
        // merge byte results into the low byte of the destination; MOVB sign-extends instead
        rfin = r;
        if (q_data.byteop && wr) begin
            if (q_data.kind == K_MOV) begin
                rfin = {{8{r[7]}}, r[7:0]};
            end else begin
                rfin = {q_data.dst[15:8], r[7:0]};
            end
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        state_next   = state_reg;
        flags_next   = flags_reg;
        m_valid_next = m_valid_reg && !m_ready;
        word_next    = word_reg;
        low_next     = low_reg;
        wr_next      = wr_reg;
        wl_next      = wl_reg;
        br_next      = br_reg;
        prod_next    = prod_reg;
        odd_next     = odd_reg;
        q_ready      = 1'b0;
        div_start    = 1'b0;
        load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_data.cls)
                        CL_ALU: begin
                            if (out_free) begin
                                q_ready    = 1'b1;
                                load       = 1'b1;
                                flags_next = nf;
                                word_next  = wr ? rfin : 16'd0;
                                low_next   = wl ? rlo : 16'd0;
                                wr_next    = wr;
                                wl_next    = wl;
                                br_next    = br;
                            end
                        end
                        CL_MUL: begin
                            q_ready    = 1'b1;
                            prod_next  = 32'($signed(q_data.dst) * $signed(q_data.src));
                            odd_next   = q_data.odd;
                            state_next = ST_MUL;
                        end
                        CL_DIV: begin
                            q_ready    = 1'b1;
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        default: begin
                            q_ready = 1'b0;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                    br_next    = 1'b0;
                    flags_next = {prod_reg[31], prod_reg == 32'd0, 1'b0,
                                  !((&prod_reg[31:15]) || !(|prod_reg[31:15]))};
                    wr_next    = 1'b1;
                    if (odd_reg) begin
                        word_next = prod_reg[15:0];
                        low_next  = 16'd0;
                        wl_next   = 1'b0;
                    end else begin
                        word_next = prod_reg[31:16];
                        low_next  = prod_reg[15:0];
                        wl_next   = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.done && out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                    br_next    = 1'b0;
                    if (div_st.div_zero) begin
                        flags_next = 4'b0011;
                        word_next  = 16'd0;
                        low_next   = 16'd0;
                        wr_next    = 1'b0;
                        wl_next    = 1'b0;
                    end else if (div_st.overflow) begin
                        flags_next = 4'b0010;
                        word_next  = 16'd0;
                        low_next   = 16'd0;
                        wr_next    = 1'b0;
                        wl_next    = 1'b0;
                    end else begin
                        flags_next = {div_q[15], div_q == 16'd0, 2'b00};
                        word_next  = div_q;
                        low_next   = div_r;
                        wr_next    = 1'b1;
                        wl_next    = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            flags_reg   <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        low_reg  <= low_next;
        wr_reg   <= wr_next;
        wl_reg   <= wl_next;
        br_reg   <= br_next;
        prod_reg <= prod_next;
        odd_reg  <= odd_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_result_word     = word_reg;
    assign m_result_low_word = low_reg;
    assign m_write_result    = wr_reg;
    assign m_write_pair_low  = wl_reg;
    assign m_branch_taken    = br_reg;
    assign m_flags_out       = flags_reg;

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == ST_IDLE)
        else $error("queue popped while a long operation is in flight");

    a_flags_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !q_valid) |=> $stable(flags_reg))
        else $error("flags changed with no operation executed");

    a_pair_implies_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_pair_low) |-> m_write_result)
        else $error("pair low write without result write");

endmodule

### hw/rtl/pdp11_alu_condition_codes.sv
// Top level of the PDP-11 ALU with N Z V C condition codes.
// Depends on pdp_pkg, pdp_front, pdp_queue, pdp_back (which holds pdp_div).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_valid / s_ready  | kind, byte_mode, operands, pair, cond/mask
//  m_      | out | m_valid / m_ready  | result words, write enables, branch, flags
//
// Order of work: ALU, shift, ccc and branch ops load the output register directly; mul loads
// the product register, then the output and flags; div starts the divider, runs its steps,
// then loads, or skips the steps on a zero divisor. A two-entry queue lets the front keep accepting.
// Reset: aresetn, synchronous, active low; clears flags to zero and empties the queue.
// Stalls: a held m_ valid transaction stalls the back end; the queue fills, then s_ready drops.
module pdp11_alu_condition_codes import pdp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_kind,
    input  logic        s_byte_mode,
    input  logic [15:0] s_source_value,
    input  logic [15:0] s_dest_value,
    input  logic [15:0] s_pair_low_value,
    input  logic        s_pair_is_odd,
    input  logic [4:0]  s_cond_or_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_word,
    output logic [15:0] m_result_low_word,
    output logic        m_write_result,
    output logic        m_write_pair_low,
    output logic        m_branch_taken,
    output logic [3:0]  m_flags_out
);

    // classified transaction from front into the queue
    logic      push_valid, push_ready;
    op_entry_t push_entry;
    // head of the queue toward the back end
    logic      head_valid, head_ready;
    op_entry_t head_entry;

    pdp_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_byte_mode      (s_byte_mode),
        .s_source_value   (s_source_value),
        .s_dest_value     (s_dest_value),
        .s_pair_low_value (s_pair_low_value),
        .s_pair_is_odd    (s_pair_is_odd),
        .s_cond_or_mask   (s_cond_or_mask),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_entry       (push_entry)
    );

    // decouple: hold up to two transactions while the back end is busy
    pdp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_entry),
        .out_valid (head_valid),
        .out_ready (head_ready),
        .out_data  (head_entry)
    );

    // execute in order; flags live here so every op sees its predecessor's flags
    pdp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (head_valid),
        .q_ready           (head_ready),
        .q_data            (head_entry),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_word     (m_result_word),
        .m_result_low_word (m_result_low_word),
        .m_write_result    (m_write_result),
        .m_write_pair_low  (m_write_pair_low),
        .m_branch_taken    (m_branch_taken),
        .m_flags_out       (m_flags_out)
    );

endmodule
